@@ sv/sirdig_pkg.sv @@
// Package: shared types and constants for the radix digit converter.
`timescale 1ns / 1ps
package sirdig_pkg;
    localparam int DIGIT_W = 4;
    localparam int RADIX_W = 5;
    localparam int SYM_W   = 64;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 2;

    localparam logic [CHAR_W-1:0]  MINUS_CHAR        = 8'h2D;
    localparam logic [RADIX_W-1:0] RADIX_RESET       = 5'd10;
    localparam logic [SYM_W-1:0]   SYMBOLS_LOW_RESET  = 64'h3736353433323130;
    localparam logic [SYM_W-1:0]   SYMBOLS_HIGH_RESET = 64'h4645444342413938;

    localparam logic [IDX_W-1:0] CFG_RADIX     = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SYM_LOW   = 2'd1;
    localparam logic [IDX_W-1:0] CFG_SYM_HIGH  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic clr;
        logic shift;
    } t_cell_ctl;
endpackage

@@ sv/sirdig_cell.sv @@
// Digit cell: one radix digit, doubles and adds a carry, shifts for readout.
`timescale 1ns / 1ps
module sirdig_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sirdig_pkg::t_cell_ctl             i_ctl,
    input  logic [sirdig_pkg::RADIX_W-1:0]    i_radix,
    input  logic                              i_step,
    input  logic                              i_carry,
    input  logic [sirdig_pkg::DIGIT_W-1:0]    i_digit,
    output logic                              o_step,
    output logic                              o_carry,
    output logic [sirdig_pkg::DIGIT_W-1:0]    o_digit
);
    logic [sirdig_pkg::DIGIT_W-1:0] r_digit, n_digit;
    logic                           r_carry, n_carry;
    logic                           r_step;
    logic [sirdig_pkg::RADIX_W-1:0] t_sum;

    always_comb begin
        t_sum   = {r_digit, i_carry};
        n_digit = r_digit;
        n_carry = r_carry;
        if (i_ctl.clr) begin
            n_digit = '0;
            n_carry = 1'b0;
        end else if (i_ctl.shift) begin
            n_digit = i_digit;
        end else if (i_step) begin
            if (t_sum >= i_radix) begin
                n_digit = sirdig_pkg::DIGIT_W'(t_sum - i_radix);
                n_carry = 1'b1;
            end else begin
                n_digit = sirdig_pkg::DIGIT_W'(t_sum);
                n_carry = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 1'b0;
        end else begin
            r_step <= i_step & ~i_ctl.clr;
        end
        r_digit <= n_digit;
        r_carry <= n_carry;
    end

    assign o_step  = r_step;
    assign o_carry = r_carry;
    assign o_digit = r_digit;
endmodule

@@ sv/signed_int_to_radix_digits_unit.sv @@
// Top level: signed integer to radix text, one character per output item.
//
//  channel | direction | handshake                  | payload
//  in      | to block  | i_in_valid / o_in_ready    | i_value
//  out     | from block| o_out_valid / i_out_ready  | o_out_char, o_is_last
//  cfg     | to block  | i_cfg_we                   | i_cfg_idx, i_cfg_wdata
//
// An item is taken in idle, then the cell row converts it (bits enter cell 0
// MSB first, carries move one cell per cycle), a minus sign follows if
// negative, then the digits are shifted out, leading zeros dropped.
// Reset is synchronous and restores radix 10 and symbols "0123456789ABCDEF".
// A stalled output holds the readout; the next item is taken once the last
// character is loaded.
`timescale 1ns / 1ps
module signed_int_to_radix_digits_unit #(
    parameter int MAX_RADIX  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [VALUE_BITS-1:0]        i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [sirdig_pkg::CHAR_W-1:0]       o_out_char,
    output logic                                o_is_last,
    input  logic                                i_cfg_we,
    input  logic [sirdig_pkg::IDX_W-1:0]        i_cfg_idx,
    input  logic [sirdig_pkg::SYM_W-1:0]        i_cfg_wdata
);
    localparam int N     = VALUE_BITS;
    localparam int CNT_W = $clog2(2 * N + 1);
    localparam logic [sirdig_pkg::RADIX_W-1:0] RMAX = sirdig_pkg::RADIX_W'(MAX_RADIX);

    sirdig_pkg::t_state r_state, n_state;
    logic [sirdig_pkg::RADIX_W-1:0] r_radix;
    logic [sirdig_pkg::SYM_W-1:0]   r_sym_lo, r_sym_hi;
    logic [N-1:0]                   r_mag, n_mag;
    logic                           r_neg, n_neg;
    logic [CNT_W-1:0]               r_cnt, n_cnt;
    logic                           r_started, n_started;
    logic                           r_ovld, n_ovld;
    logic [sirdig_pkg::CHAR_W-1:0]  r_ochar, n_ochar;
    logic                           r_olast, n_olast;
    logic [sirdig_pkg::RADIX_W-1:0] eff_radix;
    sirdig_pkg::t_cell_ctl          ctl;
    logic                           feed;
    logic                           out_free;
    logic [2*sirdig_pkg::SYM_W-1:0] sym_all;
    logic [sirdig_pkg::DIGIT_W-1:0] top_digit;

    logic                           step_c  [N+1];
    logic                           carry_c [N+1];
    logic [sirdig_pkg::DIGIT_W-1:0] digit_c [N+1];

    always_comb begin
        if (r_radix < 5'd2) eff_radix = 5'd2;
        else if (r_radix > RMAX) eff_radix = RMAX;
        else eff_radix = r_radix;
    end

    assign sym_all   = {r_sym_hi, r_sym_lo};
    assign top_digit = digit_c[N];
    assign out_free  = ~r_ovld | i_out_ready;
    assign step_c[0]  = feed;
    assign carry_c[0] = r_mag[N-1];
    assign digit_c[0] = '0;

    for (genvar g = 0; g < N; g++) begin : g_cell
        sirdig_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_radix (eff_radix),
            .i_step  (step_c[g]),
            .i_carry (carry_c[g]),
            .i_digit (digit_c[g]),
            .o_step  (step_c[g+1]),
            .o_carry (carry_c[g+1]),
            .o_digit (digit_c[g+1])
        );
    end

    always_comb begin
        n_state   = r_state;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_cnt     = r_cnt;
        n_started = r_started;
        n_ovld    = r_ovld & ~i_out_ready;
        n_ochar   = r_ochar;
        n_olast   = r_olast;
        ctl.clr   = 1'b0;
        ctl.shift = 1'b0;
        feed      = 1'b0;
        o_in_ready = 1'b0;
        unique case (r_state)
            sirdig_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_neg     = i_value[N-1];
                    n_mag     = i_value[N-1] ? (~i_value + 1'b1) : i_value;
                    n_cnt     = '0;
                    n_started = 1'b0;
                    ctl.clr   = 1'b1;
                    n_state   = sirdig_pkg::S_CONV;
                end
            end
            sirdig_pkg::S_CONV: begin
                feed  = (r_cnt < CNT_W'(N));
                if (feed) n_mag = r_mag << 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(2 * N - 1)) begin
                    n_cnt   = '0;
                    n_state = r_neg ? sirdig_pkg::S_SIGN : sirdig_pkg::S_EMIT;
                end
            end
            sirdig_pkg::S_SIGN: begin
                if (out_free) begin
                    n_ovld  = 1'b1;
                    n_ochar = sirdig_pkg::MINUS_CHAR;
                    n_olast = 1'b0;
                    n_state = sirdig_pkg::S_EMIT;
                end
            end
            sirdig_pkg::S_EMIT: begin
                if (out_free) begin
                    ctl.shift = 1'b1;
                    n_cnt     = r_cnt + 1'b1;
                    if (r_started || top_digit != '0 || r_cnt == CNT_W'(N - 1)) begin
                        n_started = 1'b1;
                        n_ovld    = 1'b1;
                        n_ochar   = sym_all[top_digit * sirdig_pkg::CHAR_W +: sirdig_pkg::CHAR_W];
                        n_olast   = (r_cnt == CNT_W'(N - 1));
                    end
                    if (r_cnt == CNT_W'(N - 1)) n_state = sirdig_pkg::S_IDLE;
                end
            end
            default: n_state = sirdig_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sirdig_pkg::S_IDLE;
            r_ovld   <= 1'b0;
            r_radix  <= sirdig_pkg::RADIX_RESET;
            r_sym_lo <= sirdig_pkg::SYMBOLS_LOW_RESET;
            r_sym_hi <= sirdig_pkg::SYMBOLS_HIGH_RESET;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sirdig_pkg::CFG_RADIX:    r_radix  <= i_cfg_wdata[sirdig_pkg::RADIX_W-1:0];
                    sirdig_pkg::CFG_SYM_LOW:  r_sym_lo <= i_cfg_wdata;
                    sirdig_pkg::CFG_SYM_HIGH: r_sym_hi <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
        r_mag     <= n_mag;
        r_neg     <= n_neg;
        r_cnt     <= n_cnt;
        r_started <= n_started;
        r_ochar   <= n_ochar;
        r_olast   <= n_olast;
    end

    assign o_out_valid = r_ovld;
    assign o_out_char  = r_ochar;
    assign o_is_last   = r_olast;
endmodule

@@ sv/sirdig_checker.sv @@
// Checker: port-level assertions for the radix digit converter, with bind.
`timescale 1ns / 1ps
module sirdig_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_char,
    input logic       o_is_last
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_char)
            && $stable(o_is_last))
        else $error("output item changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again while converting");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_is_last |=> !o_out_valid)
        else $error("character right after last item");
endmodule

bind signed_int_to_radix_digits_unit sirdig_checker u_sirdig_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_char  (o_out_char),
    .o_is_last   (o_is_last)
);

@@ sim/signed_int_to_radix_digits_unit_tb.sv @@
// Testbench: signed integer to radix text converter, checked against a behavioral predictor.
`timescale 1ns / 1ps
module signed_int_to_radix_digits_unit_tb;
    localparam int VB = 32;
    localparam int STALL_LIMIT = 20000;
    localparam logic [sirdig_pkg::IDX_W-1:0] CFG_NONE = 2'd3;

    typedef struct {
        logic [sirdig_pkg::CHAR_W-1:0] ch;
        logic                          last;
    } t_char;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [VB-1:0] i_value = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [sirdig_pkg::CHAR_W-1:0] o_out_char;
    logic o_is_last;
    logic i_cfg_we = 1'b0;
    logic [sirdig_pkg::IDX_W-1:0] i_cfg_idx = '0;
    logic [sirdig_pkg::SYM_W-1:0] i_cfg_wdata = '0;

    signed_int_to_radix_digits_unit #(.MAX_RADIX(16), .VALUE_BITS(VB)) DUT (.*);

    always #2 i_clk = ~i_clk;

    logic [sirdig_pkg::RADIX_W-1:0] cur_radix = sirdig_pkg::RADIX_RESET;
    logic [sirdig_pkg::SYM_W-1:0] cur_sym_lo = sirdig_pkg::SYMBOLS_LOW_RESET;
    logic [sirdig_pkg::SYM_W-1:0] cur_sym_hi = sirdig_pkg::SYMBOLS_HIGH_RESET;

    logic [VB-1:0] pending_values[$];
    t_char expected_chars[$];
    int send_idle_pct = 32;
    int recv_idle_pct = 50;
    int errors = 0;
    int quiet_cycles = 0;
    logic in_taken = 1'b0;

    function automatic logic [sirdig_pkg::CHAR_W-1:0] digit_symbol(input logic [3:0] d);
        if (d < 8) return cur_sym_lo[8*d +: 8];
        return cur_sym_hi[8*(d-8) +: 8];
    endfunction

    task automatic predict_text(input logic [VB-1:0] v);
        logic [VB:0] mag;
        logic [3:0] digs[$];
        int base;
        base = cur_radix;
        if (base < 2) base = 2;
        if (base > 16) base = 16;
        mag = v[VB-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
        do begin
            digs.push_front(4'(mag % base));
            mag = mag / base;
        end while (mag != 0);
        if (v[VB-1]) expected_chars.push_back('{sirdig_pkg::MINUS_CHAR, 1'b0});
        foreach (digs[k]) expected_chars.push_back('{digit_symbol(digs[k]), k == digs.size() - 1});
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                if (pending_values.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_value <= pending_values[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_taken <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                predict_text(i_value);
                void'(pending_values.pop_front());
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t: unexpected char %h last %b", $time, o_out_char, o_is_last);
                    errors++;
                end else begin
                    if (expected_chars[0].ch !== o_out_char)
                        $display("%0t: char expected %h actual %h", $time,
                                 expected_chars[0].ch, o_out_char);
                    if (expected_chars[0].last !== o_is_last)
                        $display("%0t: is_last expected %b actual %b", $time,
                                 expected_chars[0].last, o_is_last);
                    if (expected_chars[0].ch !== o_out_char ||
                        expected_chars[0].last !== o_is_last) errors++;
                    void'(expected_chars.pop_front());
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // monitor pops items at acceptance; wait for queue and pipeline to drain
    task automatic drain();
        while (pending_values.size() > 0 || i_in_valid) @(negedge i_clk);
        while (expected_chars.size() > 0) @(posedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [sirdig_pkg::IDX_W-1:0] idx,
                             input logic [sirdig_pkg::SYM_W-1:0] d);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= d;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            sirdig_pkg::CFG_RADIX:    cur_radix = d[sirdig_pkg::RADIX_W-1:0];
            sirdig_pkg::CFG_SYM_LOW:  cur_sym_lo = d;
            sirdig_pkg::CFG_SYM_HIGH: cur_sym_hi = d;
            default: ;
        endcase
    endtask

    function automatic logic [VB-1:0] random_value();
        case ($urandom_range(5))
            0: return $urandom_range(20);
            1: return -$urandom_range(20);
            2: return {1'b1, 31'($urandom_range(3))};
            3: return {1'b0, {31{1'b1}}} - $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    task automatic run_phase(input int n);
        repeat (n) pending_values.push_back(random_value());
        drain();
    endtask

    // watchdog also covers expected_chars left over: stalls count as quiet
    initial begin
        logic [VB-1:0] directed[$];
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'd10, 32'd255, 32'hAAAA_AAAA, 32'h5555_5555, 32'd123456789};
        foreach (directed[k]) pending_values.push_back(directed[k]);
        drain();
        write_reg(sirdig_pkg::CFG_RADIX, 2);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'd0);
        drain();
        write_reg(sirdig_pkg::CFG_RADIX, 16);
        write_reg(sirdig_pkg::CFG_SYM_LOW, 64'hFF00_A55A_0102_8040);
        write_reg(sirdig_pkg::CFG_SYM_HIGH, 64'h00FF_5AA5_FEFD_7FBF);
        pending_values.push_back(32'hFEDC_BA98);
        pending_values.push_back(32'h0123_4567);
        pending_values.push_back(32'h89AB_CDEF);
        drain();
        write_reg(sirdig_pkg::CFG_RADIX, 0);
        write_reg(CFG_NONE, 64'hFFFF_FFFF_FFFF_FFFF);
        pending_values.push_back(32'd5);
        drain();
        write_reg(sirdig_pkg::CFG_RADIX, 31);
        pending_values.push_back(32'hDEAD_BEEF);
        drain();
        write_reg(sirdig_pkg::CFG_RADIX, 1);
        run_phase(20);
        write_reg(sirdig_pkg::CFG_SYM_LOW, {$urandom, $urandom});
        write_reg(sirdig_pkg::CFG_SYM_HIGH, {$urandom, $urandom});
        write_reg(sirdig_pkg::CFG_RADIX, $urandom_range(2, 16));
        run_phase(45);
        send_idle_pct = 50;
        recv_idle_pct = 32;
        write_reg(sirdig_pkg::CFG_RADIX, 3);
        write_reg(sirdig_pkg::CFG_SYM_LOW, sirdig_pkg::SYMBOLS_LOW_RESET);
        write_reg(sirdig_pkg::CFG_SYM_HIGH, sirdig_pkg::SYMBOLS_HIGH_RESET);
        run_phase(45);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(sirdig_pkg::CFG_RADIX, $urandom_range(2, 16));
        run_phase(45);
        if (errors == 0 && expected_chars.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
